// ===== hw/rtl/ccl_pkg.sv =====
// shared types and constants of the two-pass component labeler
// no dependencies
`default_nettype none

package ccl_pkg;

    localparam int CFG_DATA_W  = 9;
    localparam int OUT_LABEL_W = 12;
    localparam int DIM_MIN     = 3;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // request operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel;
    } req_t;

    typedef struct packed {
        logic [OUT_LABEL_W-1:0] label;
        logic                   last;
        logic [OUT_LABEL_W-1:0] component_count;
        logic                   overflow;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ccl_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module ccl_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/two_pass_component_labeler.sv =====
// top level of the two-pass 4-connected component labeler
// depends on ccl_pkg and ccl_ram
`default_nettype none

// Load a frame in raster order (op 0), then fetch its labels in raster order (op 1).
// A border or background pixel is written from the idle state; an interior foreground
// pixel first reads the label above and, when two different labels meet, walks both
// to their roots through the table memory. After the last pixel the block resolves
// the table one provisional label at a time, while it stalls requests. A fetch reads
// the label store, then the rank table, and registers the result.
// The block starts no new transaction while a result waits on the output.
// A configuration write restarts the frame; no clearing pass is needed.
module two_pass_component_labeler #(
    parameter int MAX_LABELS = 4096,
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic                        cfg_index,
    input  wire logic [ccl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire ccl_pkg::req_t               req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output ccl_pkg::rsp_t                    rsp
);

    import ccl_pkg::*;

    localparam int LW    = $clog2(MAX_LABELS);
    localparam int NW    = LW + 1;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_UP     = 9'b000000010,
        ST_WALK_A = 9'b000000100,
        ST_WALK_B = 9'b000001000,
        ST_RES_P  = 9'b000010000,
        ST_RES_Q  = 9'b000100000,
        ST_RES_R  = 9'b001000000,
        ST_F_LAB  = 9'b010000000,
        ST_F_OUT  = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic            readout_reg, readout_next;
    logic [CW-1:0]   width_reg, width_next;
    logic [RW-1:0]   height_reg, height_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [AW-1:0]   row_base_reg, row_base_next;
    logic [NW-1:0]   next_label_reg, next_label_next;
    logic [LW-1:0]   comps_reg, comps_next;
    logic            ovf_reg, ovf_next;
    logic [LW-1:0]   left_reg, left_next;
    logic [LW-1:0]   v_reg, v_next;
    logic [LW-1:0]   walk_reg, walk_next;
    logic [LW-1:0]   ra_reg, ra_next;
    logic [AW-1:0]   pix_addr_reg, pix_addr_next;
    logic [NW-1:0]   res_idx_reg, res_idx_next;
    logic [LW-1:0]   rank_cnt_reg, rank_cnt_next;
    logic            lab_zero_reg, lab_zero_next;
    logic            last_reg, last_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_t            rsp_reg, rsp_next;

    // memory ports
    logic            ls_we, ls_re;
    logic [AW-1:0]   ls_waddr, ls_raddr;
    logic [LW-1:0]   ls_wdata, ls_rdata;
    logic            eq_we, eq_re;
    logic [LW-1:0]   eq_waddr, eq_raddr, eq_wdata, eq_rdata;
    logic            rk_we, rk_re;
    logic [LW-1:0]   rk_waddr, rk_raddr, rk_wdata, rk_rdata;

    logic            accept;
    logic            interior;
    logic [LW-1:0]   up_lab;
    logic [LW-1:0]   eq_root;
    logic [CW-1:0]   cfg_w;
    logic [RW-1:0]   cfg_h;

    ccl_ram #(.DEPTH(DEPTH), .WIDTH(LW)) u_label_store (
        .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
        .re(ls_re), .raddr(ls_raddr), .rdata(ls_rdata)
    );

    ccl_ram #(.DEPTH(MAX_LABELS), .WIDTH(LW)) u_equiv (
        .clk(clk), .we(eq_we), .waddr(eq_waddr), .wdata(eq_wdata),
        .re(eq_re), .raddr(eq_raddr), .rdata(eq_rdata)
    );

    ccl_ram #(.DEPTH(MAX_LABELS), .WIDTH(LW)) u_rank (
        .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
        .re(rk_re), .raddr(rk_raddr), .rdata(rk_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE) || rsp_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign interior = (req.pixel != 8'd0) && (row_reg != '0) && ((row_reg + 1'b1) < height_reg)
                    && (col_reg != '0) && ((col_reg + 1'b1) < width_reg);
    assign up_lab   = ls_rdata;
    assign eq_root  = (eq_rdata != '0) ? eq_rdata : walk_reg;

    // dimension clamping for configuration writes
    always_comb
    begin
        if (32'(cfg_data) < DIM_MIN)
        begin
            cfg_w = CW'(DIM_MIN);
            cfg_h = RW'(DIM_MIN);
        end
        else
        begin
            cfg_w = (32'(cfg_data) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : CW'(cfg_data);
            cfg_h = (32'(cfg_data) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(cfg_data);
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        readout_next    = readout_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        row_base_next   = row_base_reg;
        next_label_next = next_label_reg;
        comps_next      = comps_reg;
        ovf_next        = ovf_reg;
        left_next       = left_reg;
        v_next          = v_reg;
        walk_next       = walk_reg;
        ra_next         = ra_reg;
        pix_addr_next   = pix_addr_reg;
        res_idx_next    = res_idx_reg;
        rank_cnt_next   = rank_cnt_reg;
        lab_zero_next   = lab_zero_reg;
        last_next       = last_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        ls_we = 1'b0; ls_waddr = pix_addr_reg; ls_wdata = v_reg;
        ls_re = 1'b0; ls_raddr = row_base_reg + AW'(col_reg);
        eq_we = 1'b0; eq_waddr = ra_reg; eq_wdata = '0;
        eq_re = 1'b0; eq_raddr = walk_reg;
        rk_we = 1'b0; rk_waddr = res_idx_reg[LW-1:0]; rk_wdata = '0;
        rk_re = 1'b0; rk_raddr = eq_root;

        // output transaction taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.op == OP_LOAD && !readout_reg)
                begin
                    if (interior)
                    begin
                        // fetch the label above
                        ls_re         = 1'b1;
                        ls_raddr      = row_base_reg - AW'(MAX_WIDTH) + AW'(col_reg);
                        pix_addr_next = row_base_reg + AW'(col_reg);
                        state_next    = ST_UP;
                    end
                    else
                    begin
                        // border or background pixel
                        ls_we     = 1'b1;
                        ls_waddr  = row_base_reg + AW'(col_reg);
                        ls_wdata  = '0;
                        left_next = '0;
                        if ((col_reg + 1'b1) < width_reg)
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        else if ((row_reg + 1'b1) < height_reg)
                        begin
                            col_next      = '0;
                            row_next      = row_reg + 1'b1;
                            row_base_next = row_base_reg + AW'(MAX_WIDTH);
                        end
                        else
                        begin
                            // frame loaded, start resolving, or go straight to readout when no label was given
                            col_next      = '0;
                            row_next      = '0;
                            row_base_next = '0;
                            rank_cnt_next = '0;
                            if (next_label_reg == NW'(1))
                            begin
                                readout_next = 1'b1;
                                comps_next   = '0;
                            end
                            else
                            begin
                                res_idx_next = NW'(1);
                                eq_re        = 1'b1;
                                eq_raddr     = LW'(1);
                                state_next   = ST_RES_P;
                            end
                        end
                    end
                end
                else if (accept && req.op == OP_FETCH && readout_reg)
                begin
                    ls_re      = 1'b1;
                    last_next  = ((row_reg + 1'b1) == height_reg)
                              && ((col_reg + 1'b1) == width_reg);
                    state_next = ST_F_LAB;
                end
            end

            ST_UP:
            begin
                if (up_lab == '0 && left_reg == '0)
                begin
                    // new provisional label, its table entry starts as a root; on overflow the pixel gets 0
                    if (next_label_reg < NW'(MAX_LABELS))
                    begin
                        ls_wdata        = next_label_reg[LW-1:0];
                        eq_we           = 1'b1;
                        eq_waddr        = next_label_reg[LW-1:0];
                        eq_wdata        = '0;
                        next_label_next = next_label_reg + 1'b1;
                    end
                    else
                    begin
                        ls_wdata = '0;
                        ovf_next = 1'b1;
                    end
                    ls_we      = 1'b1;
                    left_next  = ls_wdata;
                    col_next   = col_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else if (up_lab == '0 || left_reg == '0 || up_lab == left_reg)
                begin
                    ls_we      = 1'b1;
                    ls_wdata   = (up_lab == '0) ? left_reg : up_lab;
                    left_next  = ls_wdata;
                    col_next   = col_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // two labels meet, walk both to their roots
                    v_next     = (up_lab < left_reg) ? up_lab : left_reg;
                    walk_next  = up_lab;
                    eq_re      = 1'b1;
                    eq_raddr   = up_lab;
                    state_next = ST_WALK_A;
                end
            end

            ST_WALK_A:
            begin
                eq_re = 1'b1;
                if (eq_rdata != '0)
                begin
                    walk_next = eq_rdata;
                    eq_raddr  = eq_rdata;
                end
                else
                begin
                    ra_next    = walk_reg;
                    walk_next  = left_reg;
                    eq_raddr   = left_reg;
                    state_next = ST_WALK_B;
                end
            end

            ST_WALK_B:
            begin
                if (eq_rdata != '0)
                begin
                    walk_next = eq_rdata;
                    eq_re     = 1'b1;
                    eq_raddr  = eq_rdata;
                end
                else
                begin
                    // link the larger root to the smaller
                    if (ra_reg > walk_reg)
                    begin
                        eq_we    = 1'b1;
                        eq_waddr = ra_reg;
                        eq_wdata = walk_reg;
                    end
                    else if (walk_reg > ra_reg)
                    begin
                        eq_we    = 1'b1;
                        eq_waddr = walk_reg;
                        eq_wdata = ra_reg;
                    end
                    ls_we      = 1'b1;
                    left_next  = v_reg;
                    col_next   = col_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_RES_P:
            begin
                if (eq_rdata == '0)
                begin
                    // root gets the next dense number
                    rk_we         = 1'b1;
                    rk_wdata      = rank_cnt_reg + 1'b1;
                    rank_cnt_next = rank_cnt_reg + 1'b1;
                    if ((res_idx_reg + 1'b1) >= next_label_reg)
                    begin
                        readout_next = 1'b1;
                        comps_next   = rank_cnt_reg + 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        res_idx_next = res_idx_reg + 1'b1;
                        eq_re        = 1'b1;
                        eq_raddr     = LW'(res_idx_reg + 1'b1);
                    end
                end
                else
                begin
                    walk_next  = eq_rdata;
                    eq_re      = 1'b1;
                    eq_raddr   = eq_rdata;
                    state_next = ST_RES_Q;
                end
            end

            ST_RES_Q:
            begin
                // parent's parent is already a root or zero
                eq_we      = 1'b1;
                eq_waddr   = res_idx_reg[LW-1:0];
                eq_wdata   = eq_root;
                rk_re      = 1'b1;
                rk_raddr   = eq_root;
                state_next = ST_RES_R;
            end

            ST_RES_R:
            begin
                rk_we    = 1'b1;
                rk_wdata = rk_rdata;
                if ((res_idx_reg + 1'b1) >= next_label_reg)
                begin
                    readout_next = 1'b1;
                    comps_next   = rank_cnt_reg;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    res_idx_next = res_idx_reg + 1'b1;
                    eq_re        = 1'b1;
                    eq_raddr     = LW'(res_idx_reg + 1'b1);
                    state_next   = ST_RES_P;
                end
            end

            ST_F_LAB:
            begin
                lab_zero_next = (ls_rdata == '0);
                rk_re         = 1'b1;
                rk_raddr      = ls_rdata;
                state_next    = ST_F_OUT;
            end

            ST_F_OUT:
            begin
                rsp_valid_next           = 1'b1;
                rsp_next.label           = lab_zero_reg ? '0 : OUT_LABEL_W'(rk_rdata);
                rsp_next.last            = last_reg;
                rsp_next.component_count = OUT_LABEL_W'(comps_reg);
                rsp_next.overflow        = ovf_reg;
                state_next               = ST_IDLE;
                if (last_reg)
                begin
                    readout_next    = 1'b0;
                    next_label_next = NW'(1);
                    comps_next      = '0;
                    ovf_next        = 1'b0;
                    col_next        = '0;
                    row_next        = '0;
                    row_base_next   = '0;
                    left_next       = '0;
                end
                else if ((col_reg + 1'b1) < width_reg)
                begin
                    col_next = col_reg + 1'b1;
                end
                else
                begin
                    col_next      = '0;
                    row_next      = row_reg + 1'b1;
                    row_base_next = row_base_reg + AW'(MAX_WIDTH);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration write restarts the frame
        if (cfg_write)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
            begin
                width_next = cfg_w;
            end
            else
            begin
                height_next = cfg_h;
            end
            state_next      = ST_IDLE;
            readout_next    = 1'b0;
            next_label_next = NW'(1);
            comps_next      = '0;
            ovf_next        = 1'b0;
            col_next        = '0;
            row_next        = '0;
            row_base_next   = '0;
            left_next       = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            readout_reg    <= 1'b0;
            width_reg      <= CW'(MAX_WIDTH < 256 ? MAX_WIDTH : 256);
            height_reg     <= RW'(MAX_HEIGHT < 256 ? MAX_HEIGHT : 256);
            col_reg        <= '0;
            row_reg        <= '0;
            row_base_reg   <= '0;
            next_label_reg <= NW'(1);
            comps_reg      <= '0;
            ovf_reg        <= 1'b0;
            left_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            readout_reg    <= readout_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            row_base_reg   <= row_base_next;
            next_label_reg <= next_label_next;
            comps_reg      <= comps_next;
            ovf_reg        <= ovf_next;
            left_reg       <= left_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        walk_reg     <= walk_next;
        ra_reg       <= ra_next;
        pix_addr_reg <= pix_addr_next;
        res_idx_reg  <= res_idx_next;
        rank_cnt_reg <= rank_cnt_next;
        lab_zero_reg <= lab_zero_next;
        last_reg     <= last_next;
        rsp_reg      <= rsp_next;
    end

endmodule

`default_nettype wire

// ===== sim/two_pass_component_labeler_test.sv =====
// testbench for two_pass_component_labeler: frames of pixels in, dense labels out
// depends on ccl_pkg and the labeler rtl; predicts every fetch result and checks it
`default_nettype none

module two_pass_component_labeler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ccl_pkg::*;

    localparam int LABEL_LIMIT = 4096;
    localparam int WIDTH_LIMIT = 256;
    localparam int HEIGHT_LIMIT = 256;

    typedef enum logic { LOADING, READOUT } frame_phase_t;
    typedef enum int { PAT_RANDOM, PAT_SOLID, PAT_COMB, PAT_DOTS, PAT_EMPTY } pattern_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    two_pass_component_labeler dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // labeling state mirrored from the block
    logic [11:0] prov_label [WIDTH_LIMIT*HEIGHT_LIMIT];
    int unsigned parent_of [LABEL_LIMIT];
    int unsigned dense_id [LABEL_LIMIT];
    int unsigned fresh_label, col, row, read_idx, comp_total, width_q, height_q;
    bit ran_out;
    frame_phase_t phase_q;

    req_t pending_reqs [$];
    rsp_t label_results [$];
    int error_count = 0;
    int result_count = 0;
    int frame_count = 0;
    int overflow_seen = 0;
    bit gaps_on = 1'b1;

    function automatic void restart_frame();
        foreach (parent_of[i]) parent_of[i] = 0;
        fresh_label = 1;
        col = 0;
        row = 0;
        phase_q = LOADING;
        read_idx = 0;
        comp_total = 0;
        ran_out = 1'b0;
    endfunction

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < DIM_MIN)
            return DIM_MIN;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned find_root(int unsigned l);
        int unsigned n = 0;
        while (l < LABEL_LIMIT && parent_of[l] != 0 && n < LABEL_LIMIT)
        begin
            l = parent_of[l];
            n++;
        end
        return (l < LABEL_LIMIT) ? l : 0;
    endfunction

    // flatten the equivalence table and number the roots densely
    function automatic void number_components();
        int unsigned n = 0;
        int unsigned p;
        for (int unsigned l = 1; l < fresh_label && l < LABEL_LIMIT; l++)
        begin
            p = parent_of[l];
            if (p != 0 && p < LABEL_LIMIT && parent_of[p] != 0)
                parent_of[l] = parent_of[p];
        end
        for (int unsigned l = 1; l < fresh_label && l < LABEL_LIMIT; l++)
        begin
            if (parent_of[l] == 0)
            begin
                n++;
                dense_id[l] = n;
            end
            else
                dense_id[l] = dense_id[parent_of[l]];
        end
        dense_id[0] = 0;
        comp_total = n;
    endfunction

    // one accepted transaction: update the mirror, queue a result for a fetch
    function automatic void label_step(req_t t);
        int unsigned up, lf, v, ra, rb, lab;
        rsp_t e;
        if (t.op == OP_LOAD)
        begin
            if (phase_q != LOADING || row >= height_q || col >= width_q)
                return;
            v = 0;
            if (t.pixel != 0 && row > 0 && row < height_q - 1 && col > 0 && col < width_q - 1)
            begin
                up = prov_label[(row - 1) * WIDTH_LIMIT + col];
                lf = prov_label[row * WIDTH_LIMIT + col - 1];
                if (up == 0 && lf == 0)
                begin
                    if (fresh_label < LABEL_LIMIT)
                    begin
                        v = fresh_label;
                        fresh_label++;
                    end
                    else
                        ran_out = 1'b1;
                end
                else if (up == 0)
                    v = lf;
                else if (lf == 0 || lf == up)
                    v = up;
                else
                begin
                    v = (up < lf) ? up : lf;
                    ra = find_root(up);
                    rb = find_root(lf);
                    if (ra > rb)
                        parent_of[ra] = rb;
                    else if (rb > ra)
                        parent_of[rb] = ra;
                end
            end
            prov_label[row * WIDTH_LIMIT + col] = v[11:0];
            col++;
            if (col >= width_q)
            begin
                col = 0;
                row++;
            end
            if (row >= height_q)
            begin
                number_components();
                phase_q = READOUT;
                read_idx = 0;
            end
        end
        else
        begin
            if (phase_q != READOUT || read_idx >= width_q * height_q)
                return;
            lab = prov_label[(read_idx / width_q) * WIDTH_LIMIT + read_idx % width_q];
            e.label = (lab != 0) ? dense_id[lab][11:0] : '0;
            e.last = (read_idx == width_q * height_q - 1);
            e.component_count = comp_total[11:0];
            e.overflow = ran_out;
            label_results.push_back(e);
            read_idx++;
            if (e.last)
                restart_frame();
        end
    endfunction

    // request driver with random gaps
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        req_t nxt;
        bit busy;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            gap_left = 0;
        end
        else
        begin
            busy = req_valid && req_stall;
            if (!busy)
            begin
                if (gap_left > 0 || pending_reqs.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    req_valid <= 1'b0;
                end
                else
                begin
                    nxt = pending_reqs.pop_front();
                    req <= nxt;
                    req_valid <= 1'b1;
                    gap_left = gaps_on ? $urandom_range(0, 5) : 0;
                end
            end
        end
    end

    // response stall generator
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                stall_left = gaps_on ? $urandom_range(0, 5) : 0;
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // monitor: register writes, accepted requests, accepted results
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                    width_q = clamp_size(cfg_data, WIDTH_LIMIT);
                else
                    height_q = clamp_size(cfg_data, HEIGHT_LIMIT);
                restart_frame();
            end
            if (req_valid && !req_stall)
                label_step(req);
            if (rsp_valid && !rsp_stall)
            begin
                result_count++;
                if (rsp.overflow)
                    overflow_seen++;
                if (rsp.last)
                    frame_count++;
                if (label_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result %p", $time, rsp);
                end
                else
                begin
                    e = label_results.pop_front();
                    if (rsp.label !== e.label || rsp.last !== e.last ||
                        rsp.component_count !== e.component_count ||
                        rsp.overflow !== e.overflow)
                    begin
                        error_count++;
                        if (error_count <= 30)
                            $display("%0t: mismatch expected %p actual %p", $time, e, rsp);
                    end
                end
            end
        end
    end

    function automatic logic [7:0] pixel_for(pattern_t p, int r, int c);
        case (p)
            PAT_SOLID: return 8'hFF;
            PAT_COMB: return (r == 1 && c % 2 == 0) ? 8'h00 : 8'h01;
            PAT_DOTS: return (r % 2 == 1 && c % 2 == 1) ? 8'h80 : 8'h00;
            PAT_EMPTY: return 8'h00;
            default: return ($urandom_range(0, 2) != 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        endcase
    endfunction

    task automatic push_req(logic op, logic [7:0] px);
        req_t t;
        t.op = op;
        t.pixel = px;
        pending_reqs.push_back(t);
    endtask

    // a whole frame: loads then fetches, with ignored transactions mixed in when noisy is set
    task automatic queue_frame(int w, int h, pattern_t p, bit noisy);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                if (noisy && $urandom_range(0, 9) == 0)
                    push_req(OP_FETCH, 8'($urandom));
                push_req(OP_LOAD, pixel_for(p, r, c));
            end
        for (int i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_req(OP_LOAD, 8'($urandom));
            push_req(OP_FETCH, 8'($urandom));
        end
    endtask

    task automatic drain(int settle);
        while (pending_reqs.size() != 0 || req_valid || label_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_frame(int unsigned w, int unsigned h, pattern_t p, bit noisy);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        queue_frame(clamp_size(w, WIDTH_LIMIT), clamp_size(h, HEIGHT_LIMIT), p, noisy);
        drain(10);
    endtask

    // stimulus
    initial
    begin
        int random_items;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data = '0;
        width_q = WIDTH_LIMIT;
        height_q = HEIGHT_LIMIT;
        restart_frame();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: size clamping, fetch while loading, merges, empty frame
        push_req(OP_FETCH, 8'hFF);
        drain(2);
        run_frame(0, 2, PAT_SOLID, 1'b0);
        run_frame(7, 5, PAT_COMB, 1'b1);
        run_frame(6, 4, PAT_EMPTY, 1'b0);

        // restart in the middle of loading
        write_reg(CFG_FRAME_WIDTH, 9);
        write_reg(CFG_FRAME_HEIGHT, 9);
        for (int i = 0; i < 20; i++)
            push_req(OP_LOAD, 8'hFF);
        drain(300);
        run_frame(5, 5, PAT_SOLID, 1'b0);

        // random frames
        random_items = 0;
        while (random_items < 320)
        begin
            int unsigned w, h;
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 10);
            gaps_on = ($urandom_range(0, 3) != 0);
            run_frame(w, h, PAT_RANDOM, 1'b1);
            random_items += 2 * w * h;
        end

        drain(20);
        $display("checked %0d labels over %0d frames, %0d with overflow set",
                 result_count, frame_count, overflow_seen);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
